[src/flash_block_page_tracker_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the flash block page tracker
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FLASH_BLOCK_PAGE_TRACKER_CORE_ASSERT_SVH
`define FLASH_BLOCK_PAGE_TRACKER_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define FBPT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define FBPT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/fbpt_pkg.sv]
// ----------------------------------------------------------------------------
// fbpt_pkg
// Types, codes and sizes for the flash block page tracker.
// ----------------------------------------------------------------------------
package fbpt_pkg;

  // Block geometry
  localparam int PAGES_PER_BLOCK = 64;
  localparam int PAGE_IDX_W      = $clog2(PAGES_PER_BLOCK);
  localparam int COUNT_W         = $clog2(PAGES_PER_BLOCK + 1);

  // Empty-page search: one group of pages per cycle
  localparam int SCAN_W      = (PAGES_PER_BLOCK < 16) ? PAGES_PER_BLOCK : 16;
  localparam int SCAN_CHUNKS = (PAGES_PER_BLOCK + SCAN_W - 1) / SCAN_W;
  localparam int SCAN_PAD    = SCAN_CHUNKS * SCAN_W;
  localparam int CHUNK_W     = (SCAN_CHUNKS > 1) ? $clog2(SCAN_CHUNKS) : 1;
  localparam int BIT_W       = $clog2(SCAN_W);

  // Block base: a mask for power-of-two blocks, else reciprocal multiplication
  localparam bit BASE_POW2 = (PAGES_PER_BLOCK & (PAGES_PER_BLOCK - 1)) == 0;

  // Field widths
  localparam int MODE_W       = 3;
  localparam int PAGE_FIELD_W = 6;
  localparam int STATUS_W     = 3;
  localparam int PSTATE_W     = 2;
  localparam int BSTATE_W     = 2;
  localparam int PAGES_W      = 7;
  localparam int ERASE_W      = 20;
  localparam int ADDR_W       = 32;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 80;
  localparam int OUT_USED_W   = STATUS_W + PSTATE_W + BSTATE_W + 2 * PAGES_W
                                + ERASE_W + ADDR_W;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  // Truncated reciprocal of the block size; the quotient it gives is at most one short
  localparam logic [ADDR_W-1:0] BASE_RECIP = ADDR_W'((64'd1 << ADDR_W) / PAGES_PER_BLOCK);

  localparam logic [ERASE_W-1:0] ERASE_LIMIT_RESET = 20'd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_ADDRESS = 1'b0,
    CFG_ERASE_LIMIT   = 1'b1
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ       = 3'd0,
    MODE_PROGRAM    = 3'd1,
    MODE_INVALIDATE = 3'd2,
    MODE_ERASE      = 3'd3,
    MODE_FIND       = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_ORDER      = 3'd1,
    ST_NOT_EMPTY  = 3'd2,
    ST_WORN       = 3'd3,
    ST_NOT_VALID  = 3'd4,
    ST_NONE_EMPTY = 3'd5
  } status_t;

  typedef enum logic [PSTATE_W-1:0] {
    PG_EMPTY   = 2'd0,
    PG_VALID   = 2'd1,
    PG_INVALID = 2'd2
  } page_state_t;

  typedef enum logic [BSTATE_W-1:0] {
    BLK_FREE     = 2'd0,
    BLK_PARTIAL  = 2'd1,
    BLK_ACTIVE   = 2'd2,
    BLK_INACTIVE = 2'd3
  } blk_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_BASE,
    S_DONE
  } seq_state_t;

endpackage

[src/flash_block_page_tracker_core.sv]
// Read, program, invalidate, erase: a request steps S_READ, S_EXEC, S_DONE, then m_tvalid.
// Find empty adds S_SCAN once per 16-page group until a hit or the last group,
// plus S_BASE to form the block base when the block size is not a power of two.
// One request at a time (s_tready only in S_IDLE); a stalled result holds off the next.
// Reset (rst, synchronous): all pages empty, counts zero, block free, erase count zero,
// block_address 0 and erase_limit 100000; no clearing pass is needed.
// ----------------------------------------------------------------------------
// flash_block_page_tracker_core
// Page state tracker for one NAND erase block: per-page state, valid and
// invalid counts, block condition and wear, driven by a small sequencer.
// ----------------------------------------------------------------------------
`include "flash_block_page_tracker_core_assert.svh"

module flash_block_page_tracker_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [fbpt_pkg::IN_TDATA_W-1:0]    s_tdata,   // mode [2:0], page_index [8:3]
  input  logic [0:0]                         s_tuser,   // noop [0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status [2:0], page_cond [4:3], block_cond [6:5], valid_pages [13:7],
  // invalid_pages [20:14], erases_used [40:21], next_page_address [72:41]
  output logic [fbpt_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               cfg_we,
  input  logic [fbpt_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [fbpt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import fbpt_pkg::*;

  // Sequencer
  seq_state_t state, state_next;

  // Configuration
  logic [ADDR_W-1:0]  block_address;
  logic [ERASE_W-1:0] erase_limit;

  // Block state
  logic [PAGES_PER_BLOCK-1:0] page_used;
  logic [COUNT_W-1:0]         valid_count;
  logic [COUNT_W-1:0]         invalid_count;
  blk_state_t                 block_condition;
  logic [ERASE_W-1:0]         erase_count;

  // Request held while it is worked on
  logic [MODE_W-1:0]       req_mode;
  logic [PAGE_FIELD_W-1:0] req_page;
  logic                    req_noop;

  // Result being assembled
  status_t           pend_status;
  page_state_t       pend_page_state;
  logic [ADDR_W-1:0] pend_addr;
  logic [PAGE_IDX_W-1:0] found_page;

  // Search iteration and block base
  logic [CHUNK_W-1:0] scan_chunk;
  logic [ADDR_W-1:0]  base_quot;
  logic [ADDR_W-1:0]  base_prod;

  // Page state RAM
  logic                  ram_we;
  logic [PSTATE_W-1:0]   ram_rdata;
  page_state_t           exec_wdata;

  // Decode
  logic                  in_range;
  logic [PAGE_IDX_W-1:0] page_addr;
  logic [PAGE_IDX_W-1:0] prev_addr;
  logic                  cur_used;
  logic                  prev_used;
  page_state_t           cur_state;
  logic [COUNT_W:0]      sum_now;
  logic [COUNT_W:0]      sum_prog;
  logic [COUNT_W-1:0]    inv_inc;

  // Execute decisions
  status_t     exec_status;
  page_state_t exec_page_state;
  logic        exec_write;
  logic        exec_prog;
  logic        exec_inval;
  logic        exec_erase;

  // Search unit
  logic [SCAN_PAD-1:0]   scan_vec;
  logic [SCAN_W-1:0]     chunk_bits;
  logic                  scan_hit;
  logic [BIT_W-1:0]      hit_bit;
  logic [PAGE_IDX_W-1:0] hit_page;
  logic                  scan_last;

  // Block base unit
  logic [2*ADDR_W-1:0] quot_full;
  logic [ADDR_W-1:0]   base_rem;
  logic [ADDR_W-1:0]   base_fix;

  // Control
  logic out_free;
  logic out_load;
  logic in_accept;

  // Page state store
  fbpt_ram #(
    .WIDTH (PSTATE_W),
    .DEPTH (PAGES_PER_BLOCK)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (page_addr),
    .wdata (exec_wdata),
    .raddr (page_addr),
    .rdata (ram_rdata)
  );

  // Decode the addressed page and its neighbour
  always_comb begin
    in_range  = int'(req_page) < PAGES_PER_BLOCK;
    page_addr = PAGE_IDX_W'(req_page);
    prev_addr = page_addr - PAGE_IDX_W'(1);
    cur_used  = in_range && page_used[page_addr];
    prev_used = (page_addr == '0) || page_used[prev_addr];
    cur_state = cur_used ? page_state_t'(ram_rdata) : PG_EMPTY;
    sum_now   = {1'b0, valid_count} + {1'b0, invalid_count};
    sum_prog  = sum_now + (COUNT_W + 1)'(1);
    inv_inc   = invalid_count + COUNT_W'(1);
  end

  // Decide the operation's outcome
  always_comb begin
    exec_status     = ST_OK;
    exec_page_state = cur_state;
    exec_write      = 1'b0;
    exec_wdata      = PG_VALID;
    exec_prog       = 1'b0;
    exec_inval      = 1'b0;
    exec_erase      = 1'b0;
    case (req_mode)
      MODE_PROGRAM: begin
        if (!req_noop) begin
          if (!in_range) begin
            exec_status = ST_NOT_VALID;
          end else if (!prev_used) begin
            exec_status = ST_ORDER;
          end else if (cur_used) begin
            exec_status = ST_NOT_EMPTY;
          end else begin
            exec_write      = 1'b1;
            exec_prog       = 1'b1;
            exec_page_state = PG_VALID;
          end
        end
      end
      MODE_INVALIDATE: begin
        if (!req_noop) begin
          if (!in_range) begin
            exec_status = ST_NOT_VALID;
          end else if (cur_state == PG_INVALID) begin
            exec_status = ST_OK;
          end else if (!cur_used) begin
            exec_status = ST_NOT_VALID;
          end else begin
            exec_write      = 1'b1;
            exec_wdata      = PG_INVALID;
            exec_inval      = 1'b1;
            exec_page_state = PG_INVALID;
          end
        end
      end
      MODE_ERASE: begin
        if (!req_noop) begin
          if (erase_count >= erase_limit) begin
            exec_status = ST_WORN;
          end else begin
            exec_erase      = 1'b1;
            exec_page_state = PG_EMPTY;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Pad the used-page vector to whole search groups
  for (genvar g = 0; g < SCAN_PAD; g++) begin : g_scan_pad
    if (g < PAGES_PER_BLOCK) begin : g_page
      assign scan_vec[g] = page_used[g];
    end else begin : g_fill
      assign scan_vec[g] = 1'b1;
    end
  end

  // Search one group for its lowest empty page
  always_comb begin
    chunk_bits = scan_vec[int'(scan_chunk) * SCAN_W +: SCAN_W];
    scan_hit   = 1'b0;
    hit_bit    = '0;
    for (int j = SCAN_W - 1; j >= 0; j--) begin
      if (!chunk_bits[j]) begin
        scan_hit = 1'b1;
        hit_bit  = BIT_W'(j);
      end
    end
    hit_page  = PAGE_IDX_W'(int'(scan_chunk) * SCAN_W + int'(hit_bit));
    scan_last = int'(scan_chunk) == SCAN_CHUNKS - 1;
  end

  // Block base by reciprocal multiplication; a quotient one short is put right once
  always_comb begin
    quot_full = {{ADDR_W{1'b0}}, block_address} * {{ADDR_W{1'b0}}, BASE_RECIP};
    base_rem  = block_address - base_prod;
    if (base_rem >= ADDR_W'(PAGES_PER_BLOCK)) begin
      base_fix = base_prod + ADDR_W'(PAGES_PER_BLOCK);
    end else begin
      base_fix = base_prod;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (req_mode == MODE_FIND) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = BASE_POW2 ? S_DONE : S_BASE;
        end else if (scan_last) begin
          state_next = S_DONE;
        end
      end
      S_BASE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    out_free  = !m_tvalid || m_tready;
    s_tready  = (state == S_IDLE);
    in_accept = s_tvalid && s_tready;
    ram_we    = (state == S_EXEC) && exec_write;
    out_load  = (state == S_DONE) && out_free;
  end

  // Control registers and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      block_address   <= '0;
      erase_limit     <= ERASE_LIMIT_RESET;
      page_used       <= '0;
      valid_count     <= '0;
      invalid_count   <= '0;
      block_condition <= BLK_FREE;
      erase_count     <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;

      // Configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BLOCK_ADDRESS: block_address <= cfg_wdata;
          CFG_ERASE_LIMIT:   erase_limit   <= cfg_wdata[ERASE_W-1:0];
          default: begin
          end
        endcase
      end

      // Apply the operation
      if (state == S_EXEC) begin
        if (exec_prog) begin
          page_used[page_addr] <= 1'b1;
          valid_count          <= valid_count + COUNT_W'(1);
          if (sum_prog < (COUNT_W + 1)'(PAGES_PER_BLOCK)) begin
            block_condition <= BLK_PARTIAL;
          end else begin
            block_condition <= BLK_ACTIVE;
          end
        end
        if (exec_inval) begin
          invalid_count <= inv_inc;
          valid_count   <= valid_count - COUNT_W'(1);
          if (inv_inc == COUNT_W'(PAGES_PER_BLOCK)) begin
            block_condition <= BLK_INACTIVE;
          end else if (sum_now == (COUNT_W + 1)'(PAGES_PER_BLOCK)) begin
            block_condition <= BLK_ACTIVE;
          end
        end
        if (exec_erase) begin
          page_used       <= '0;
          valid_count     <= '0;
          invalid_count   <= '0;
          block_condition <= BLK_FREE;
          erase_count     <= erase_count + ERASE_W'(1);
        end
      end

      // Hand the result over
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request, iteration and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_mode <= s_tdata[MODE_W-1:0];
      req_page <= s_tdata[MODE_W +: PAGE_FIELD_W];
      req_noop <= s_tuser[0];
    end

    if (state == S_EXEC) begin
      pend_status     <= exec_status;
      pend_page_state <= exec_page_state;
      pend_addr       <= '0;
      scan_chunk      <= '0;
      if (!BASE_POW2) begin
        base_quot <= quot_full[2*ADDR_W-1:ADDR_W];
      end
    end

    // Advance the search one group at a time
    if (state == S_SCAN) begin
      scan_chunk <= scan_chunk + CHUNK_W'(1);
      found_page <= hit_page;
      if (!BASE_POW2) begin
        base_prod <= ADDR_W'(base_quot * ADDR_W'(PAGES_PER_BLOCK));
      end
      if (scan_hit) begin
        if (BASE_POW2) begin
          pend_addr <= (block_address & ~ADDR_W'(PAGES_PER_BLOCK - 1))
                       + ADDR_W'(hit_page);
        end
      end else if (scan_last) begin
        pend_status <= ST_NONE_EMPTY;
      end
    end

    // Add the found page to the corrected block base
    if (state == S_BASE) begin
      pend_addr <= base_fix + ADDR_W'(found_page);
    end

    if (out_load) begin
      m_tdata <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                  pend_addr,
                  ERASE_W'(erase_count),
                  PAGES_W'(invalid_count),
                  PAGES_W'(valid_count),
                  block_condition,
                  pend_page_state,
                  pend_status};
    end
  end

  // Consistency of counters, used-page bits and block condition
  `FBPT_ASSERT_ALWAYS(a_count_match,
    $countones(page_used) == (int'(valid_count) + int'(invalid_count)),
    "page counts disagree with used-page bits")
  `FBPT_ASSERT_IMPLIES(a_free_empty, block_condition == BLK_FREE, page_used == '0,
    "free block holds used pages")
  `FBPT_ASSERT_IMPLIES(a_inactive_no_valid, block_condition == BLK_INACTIVE,
    valid_count == '0, "inactive block holds valid pages")
  `FBPT_ASSERT_IMPLIES(a_active_full, block_condition == BLK_ACTIVE,
    sum_now == (COUNT_W + 1)'(PAGES_PER_BLOCK), "active block has empty pages")

endmodule

[src/fbpt_ram.sv]
// ----------------------------------------------------------------------------
// fbpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpt_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
